/* hdl/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared widths, codes and control/status types of the running statistics
// accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 24;
    localparam int FRAC_W    = 8;
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 56;
    localparam int MINMAX_W  = 16;
    localparam int MEAN_W    = 24;
    localparam int VAR_W     = 40;
    localparam int DEV_W     = 24;
    localparam int PCT_W     = 15;
    localparam int FEAT_W    = 5;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // datapath widths
    localparam int PROD_W    = COUNT_W + SQ_W;           // n*sumsq and sum^2
    localparam int DNUM_W    = PROD_W + FRAC_W;          // divider dividend
    localparam int DEN_W     = 2 * COUNT_W;              // n*(n-1)
    localparam int MNUM_W    = SUM_W + FRAC_W + 1;       // |sum|<<F + n/2
    localparam int PCT_MUL_W = COUNT_W + 7;              // count*100
    localparam int PNUM_W    = PCT_MUL_W + FRAC_W;
    localparam int DSTEP_W   = $clog2(DNUM_W + 1);
    localparam int STEP_W    = $clog2(SUM_W + 1);
    localparam int PCT_SCALE = 100;

    // feature enable bits
    localparam int FE_MIN  = 0;
    localparam int FE_MAX  = 1;
    localparam int FE_DEV  = 2;
    localparam int FE_VAR  = 3;
    localparam int FE_PCT  = 4;

    // input operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEATURE   = 2'd0,
        REG_MATCH_EN  = 2'd1,
        REG_MATCH_VAL = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_VAR  = 2'd0,
        DIV_PCT  = 2'd1,
        DIV_MEAN = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_A,
        S_MUL_B_GO,
        S_MUL_B,
        S_VAR_GO,
        S_VAR_DIV,
        S_VAR_DONE,
        S_SQRT,
        S_DEV_DONE,
        S_PCT_CHECK,
        S_PCT_DIV,
        S_MEAN_GO,
        S_MEAN_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     mul_load_a;
        logic     mul_load_b;
        logic     mul_step;
        logic     div_start;
        t_div_sel div_sel;
        logic     var_store;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     dev_store;
        logic     pct_store;
        logic     mean_store;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic in_op;
        logic cnt_full;
        logic need_var;
        logic need_dev;
        logic need_pct;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

/* hdl/rsa_if.sv */
// ----------------------------------------------------------------------------
// rsa_in_if / rsa_out_if
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface rsa_in_if;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic signed [15:0]   sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rsa_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   min_value;
    logic signed [15:0]   max_value;
    logic signed [23:0]   mean_value;
    logic        [39:0]   variance_value;
    logic        [23:0]   deviation_value;
    logic        [23:0]   match_count;
    logic        [14:0]   match_percent;
    logic        [23:0]   samples_seen;
    logic                 saturated;

    modport source (output valid, output min_value, output max_value, output mean_value,
                    output variance_value, output deviation_value, output match_count,
                    output match_percent, output samples_seen, output saturated,
                    input ready);
    modport sink   (input valid, input min_value, input max_value, input mean_value,
                    input variance_value, input deviation_value, input match_count,
                    input match_percent, input samples_seen, input saturated,
                    output ready);
endinterface

/* hdl/rsa_div.sv */
// ----------------------------------------------------------------------------
// rsa_div
// Serial restoring divider, one quotient bit per cycle, shared by variance,
// percentage and mean. Keeps the low quotient bits and a sticky overflow.
// ----------------------------------------------------------------------------
module rsa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rsa_pkg::DNUM_W-1:0]  i_num,
    input  logic [rsa_pkg::DEN_W-1:0]   i_den,
    input  logic [rsa_pkg::DSTEP_W-1:0] i_steps,
    output logic                        o_busy,
    output logic [rsa_pkg::VAR_W-1:0]   o_quot,
    output logic                        o_ovf
);
    import rsa_pkg::*;

    logic                r_busy;
    logic [DSTEP_W-1:0]  r_cnt;
    logic [DNUM_W-1:0]   r_num;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [VAR_W-1:0]    r_quot;
    logic                r_ovf;

    logic [DEN_W:0]      trial;
    logic                ge;
    logic [DEN_W:0]      diff;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_num[DNUM_W-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DSTEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[DNUM_W-2:0], 1'b0};
            r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[VAR_W-2:0], ge};
            r_ovf  <= r_ovf | r_quot[VAR_W-1];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

/* hdl/rsa_datapath.sv */
// ----------------------------------------------------------------------------
// rsa_datapath
// Statistics state, configuration, shift-add multiplier, serial square root,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module rsa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsa_pkg::t_cmd                 i_cmd,
    output rsa_pkg::t_status              o_status,
    input  logic                          i_in_op,
    input  logic signed [rsa_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                          i_cfg_we,
    input  logic [rsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsa_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic signed [rsa_pkg::MINMAX_W-1:0] o_min_value,
    output logic signed [rsa_pkg::MINMAX_W-1:0] o_max_value,
    output logic signed [rsa_pkg::MEAN_W-1:0]   o_mean_value,
    output logic [rsa_pkg::VAR_W-1:0]     o_variance_value,
    output logic [rsa_pkg::DEV_W-1:0]     o_deviation_value,
    output logic [rsa_pkg::COUNT_W-1:0]   o_match_count,
    output logic [rsa_pkg::PCT_W-1:0]     o_match_percent,
    output logic [rsa_pkg::COUNT_W-1:0]   o_samples_seen,
    output logic                          o_saturated
);
    import rsa_pkg::*;

    // configuration
    logic [FEAT_W-1:0]          r_fe;
    logic                       r_me;
    logic signed [CFG_W-1:0]    r_mv;

    // statistics
    logic [COUNT_W-1:0]         r_cnt;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sq;
    logic signed [MINMAX_W-1:0] r_min;
    logic signed [MINMAX_W-1:0] r_max;
    logic [COUNT_W-1:0]         r_mcnt;
    logic [VAR_W-1:0]           r_var;
    logic [DEV_W-1:0]           r_dev;
    logic [PCT_W-1:0]           r_pct;
    logic                       r_full;
    logic signed [MEAN_W-1:0]   r_mean;

    // multiplier
    logic [PROD_W-1:0]          r_mul_acc;
    logic [SQ_W-1:0]            r_mul_a;
    logic [SUM_W-1:0]           r_mul_b;
    logic [PROD_W-1:0]          r_prod_a;
    logic [DEN_W-1:0]           r_den;

    // square root
    logic [2*DEV_W-1:0]         r_sr_x;
    logic [DEV_W+1:0]           r_sr_rem;
    logic [DEV_W-1:0]           r_sr_root;

    // output register
    logic                       r_out_valid;

    logic [COUNT_W-1:0]         n_cnt;
    logic signed [SUM_W-1:0]    x_ext;
    logic signed [2*SAMPLE_W-1:0] x_sq;
    logic                       is_match;
    logic [SUM_W-1:0]           sum_mag;
    logic [COUNT_W-1:0]         cnt_m1;
    logic [DEN_W-1:0]           den_c;
    logic [PROD_W:0]            vdiff;
    logic [PROD_W-1:0]          vnum;
    logic [MNUM_W-1:0]          mnum;
    logic [PCT_MUL_W-1:0]       pmul;
    logic [PNUM_W-1:0]          pnum;
    logic [DNUM_W-1:0]          div_num;
    logic [DEN_W-1:0]           div_den;
    logic [DSTEP_W-1:0]         div_steps;
    logic                       div_busy;
    logic [VAR_W-1:0]           div_q;
    logic                       div_ovf;
    logic [VAR_W-1:0]           v_sat;
    logic [DEV_W+3:0]           sr_t;
    logic [DEV_W+3:0]           sr_trial;
    logic [VAR_W-1:0]           half;
    logic signed [MEAN_W-1:0]   mean_c;
    logic                       sum_neg;

    // sample side terms
    always_comb begin
        n_cnt    = r_cnt + 1'b1;
        x_ext    = SUM_W'(i_in_sample);
        x_sq     = i_in_sample * i_in_sample;
        is_match = r_me && (i_in_sample == r_mv);
        sum_neg  = r_sum[SUM_W-1];
        sum_mag  = sum_neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        cnt_m1   = r_cnt - 1'b1;
        den_c    = r_cnt * cnt_m1;
    end

    // divider operand select
    always_comb begin
        vdiff = {1'b0, r_prod_a} - {1'b0, r_mul_acc};
        vnum  = vdiff[PROD_W] ? '0 : vdiff[PROD_W-1:0];
        mnum  = {1'b0, sum_mag, {FRAC_W{1'b0}}} + MNUM_W'(r_cnt >> 1);
        pmul  = PCT_MUL_W'(r_mcnt) * PCT_MUL_W'(PCT_SCALE);
        pnum  = {pmul, {FRAC_W{1'b0}}};
        unique case (i_cmd.div_sel)
            DIV_VAR: begin
                div_num   = {vnum, {FRAC_W{1'b0}}};
                div_den   = r_den;
                div_steps = DSTEP_W'(DNUM_W);
            end
            DIV_PCT: begin
                div_num   = {pnum, {(DNUM_W-PNUM_W){1'b0}}};
                div_den   = DEN_W'(r_cnt);
                div_steps = DSTEP_W'(PNUM_W);
            end
            DIV_MEAN: begin
                div_num   = {mnum, {(DNUM_W-MNUM_W){1'b0}}};
                div_den   = DEN_W'(r_cnt);
                div_steps = DSTEP_W'(MNUM_W);
            end
            default: begin
                div_num   = '0;
                div_den   = DEN_W'(r_cnt);
                div_steps = '0;
            end
        endcase
    end

    rsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_quot  (div_q),
        .o_ovf   (div_ovf)
    );

    // quotient post-processing: variance clamp and rounded, clamped mean
    always_comb begin
        v_sat = div_ovf ? '1 : div_q;
        half  = VAR_W'(1) << (MEAN_W - 1);
        if (div_ovf || div_q > half) begin
            mean_c = sum_neg ? {1'b1, {(MEAN_W-1){1'b0}}} : {1'b0, {(MEAN_W-1){1'b1}}};
        end else if (div_q == half) begin
            mean_c = sum_neg ? {1'b1, {(MEAN_W-1){1'b0}}} : {1'b0, {(MEAN_W-1){1'b1}}};
        end else begin
            mean_c = sum_neg ? -div_q[MEAN_W-1:0] : div_q[MEAN_W-1:0];
        end
    end

    // square root digit step
    always_comb begin
        sr_t     = {r_sr_rem, r_sr_x[2*DEV_W-1 -: 2]};
        sr_trial = {2'b00, r_sr_root, 2'b01};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe <= '0;
            r_me <= 1'b0;
            r_mv <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FEATURE:   r_fe <= i_cfg_data[FEAT_W-1:0];
                REG_MATCH_EN:  r_me <= i_cfg_data[0];
                REG_MATCH_VAL: r_mv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_min  <= '0;
            r_max  <= '0;
            r_mcnt <= '0;
            r_var  <= '0;
            r_dev  <= '0;
            r_pct  <= '0;
            r_full <= 1'b0;
            r_mean <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_in_op == OP_CLEAR) begin
                    r_cnt  <= '0;
                    r_sum  <= '0;
                    r_sq   <= '0;
                    r_min  <= '0;
                    r_max  <= '0;
                    r_mcnt <= '0;
                    r_var  <= '0;
                    r_dev  <= '0;
                    r_pct  <= '0;
                    r_full <= 1'b0;
                    r_mean <= '0;
                end else if (&r_cnt) begin
                    r_full <= 1'b1;
                end else begin
                    r_cnt <= n_cnt;
                    r_sum <= r_sum + x_ext;
                    r_sq  <= r_sq + SQ_W'(unsigned'(x_sq));
                    if (is_match) begin
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                    if (r_fe[FE_MIN]) begin
                        r_min <= (r_cnt != '0 && r_min < i_in_sample) ? r_min : i_in_sample;
                    end
                    if (r_fe[FE_MAX]) begin
                        r_max <= (r_cnt != '0 && r_max > i_in_sample) ? r_max : i_in_sample;
                    end
                end
            end
            if (i_cmd.var_store && r_fe[FE_VAR]) begin
                r_var <= v_sat;
            end
            if (i_cmd.dev_store) begin
                r_dev <= r_sr_root;
            end
            if (i_cmd.pct_store) begin
                r_pct <= div_q[PCT_W-1:0];
            end
            if (i_cmd.mean_store) begin
                r_mean <= mean_c;
            end
        end
    end

    // shift-add multiplier and square root working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load_a) begin
            r_mul_acc <= '0;
            r_mul_a   <= r_sq;
            r_mul_b   <= {r_cnt, {(SUM_W-COUNT_W){1'b0}}};
        end else if (i_cmd.mul_load_b) begin
            r_prod_a  <= r_mul_acc;
            r_den     <= den_c;
            r_mul_acc <= '0;
            r_mul_a   <= SQ_W'(sum_mag);
            r_mul_b   <= sum_mag;
        end else if (i_cmd.mul_step) begin
            r_mul_acc <= {r_mul_acc[PROD_W-2:0], 1'b0}
                         + (r_mul_b[SUM_W-1] ? PROD_W'(r_mul_a) : '0);
            r_mul_b   <= {r_mul_b[SUM_W-2:0], 1'b0};
        end
        if (i_cmd.sqrt_load) begin
            r_sr_x    <= {v_sat, {FRAC_W{1'b0}}};
            r_sr_rem  <= '0;
            r_sr_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sr_x <= {r_sr_x[2*DEV_W-3:0], 2'b00};
            if (sr_t >= sr_trial) begin
                r_sr_rem  <= (DEV_W+2)'(sr_t - sr_trial);
                r_sr_root <= {r_sr_root[DEV_W-2:0], 1'b1};
            end else begin
                r_sr_rem  <= sr_t[DEV_W+1:0];
                r_sr_root <= {r_sr_root[DEV_W-2:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_min_value       <= r_fe[FE_MIN] ? r_min : '0;
            o_max_value       <= r_fe[FE_MAX] ? r_max : '0;
            o_mean_value      <= r_mean;
            o_variance_value  <= r_fe[FE_VAR] ? r_var : '0;
            o_deviation_value <= r_fe[FE_DEV] ? r_dev : '0;
            o_match_count     <= r_mcnt;
            o_match_percent   <= r_fe[FE_PCT] ? r_pct : '0;
            o_samples_seen    <= r_cnt;
            o_saturated       <= r_full;
        end
    end

    assign o_res_valid = r_out_valid;

    // status to the controller
    always_comb begin
        o_status.in_op    = i_in_op;
        o_status.cnt_full = &r_cnt;
        o_status.need_var = (r_cnt > COUNT_W'(1)) && (r_fe[FE_VAR] || r_fe[FE_DEV]);
        o_status.need_dev = r_fe[FE_DEV];
        o_status.need_pct = r_fe[FE_PCT] && r_me;
        o_status.div_busy = div_busy;
        o_status.out_free = !r_out_valid || i_res_ready;
    end

endmodule

/* hdl/rsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer: steps the multiplier, divider and square root for one beat and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rsa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rsa_pkg::t_status i_status,
    output rsa_pkg::t_cmd    o_cmd
);
    import rsa_pkg::*;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               fire;

    assign fire = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (fire) begin
                    n_state = (i_status.in_op == OP_CLEAR || i_status.cnt_full) ?
                              S_DONE : S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.need_var) begin
                    n_state = S_MUL_A;
                    n_step  = STEP_W'(COUNT_W - 1);
                end else begin
                    n_state = S_PCT_CHECK;
                end
            end
            S_MUL_A: begin
                if (r_step == '0) n_state = S_MUL_B_GO;
                else              n_step  = r_step - 1'b1;
            end
            S_MUL_B_GO: begin
                n_state = S_MUL_B;
                n_step  = STEP_W'(SUM_W - 1);
            end
            S_MUL_B: begin
                if (r_step == '0) n_state = S_VAR_GO;
                else              n_step  = r_step - 1'b1;
            end
            S_VAR_GO:  n_state = S_VAR_DIV;
            S_VAR_DIV: begin
                if (!i_status.div_busy) n_state = S_VAR_DONE;
            end
            S_VAR_DONE: begin
                if (i_status.need_dev) begin
                    n_state = S_SQRT;
                    n_step  = STEP_W'(DEV_W - 1);
                end else begin
                    n_state = S_PCT_CHECK;
                end
            end
            S_SQRT: begin
                if (r_step == '0) n_state = S_DEV_DONE;
                else              n_step  = r_step - 1'b1;
            end
            S_DEV_DONE:  n_state = S_PCT_CHECK;
            S_PCT_CHECK: n_state = i_status.need_pct ? S_PCT_DIV : S_MEAN_GO;
            S_PCT_DIV: begin
                if (!i_status.div_busy) n_state = S_MEAN_GO;
            end
            S_MEAN_GO:  n_state = S_MEAN_DIV;
            S_MEAN_DIV: begin
                if (!i_status.div_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_MEAN;
        o_in_ready    = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE:     o_cmd.accept = fire;
            S_CHECK:    o_cmd.mul_load_a = i_status.need_var;
            S_MUL_A:    o_cmd.mul_step = 1'b1;
            S_MUL_B_GO: o_cmd.mul_load_b = 1'b1;
            S_MUL_B:    o_cmd.mul_step = 1'b1;
            S_VAR_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VAR;
            end
            S_VAR_DIV:  o_cmd.div_sel = DIV_VAR;
            S_VAR_DONE: begin
                o_cmd.var_store = 1'b1;
                o_cmd.sqrt_load = i_status.need_dev;
            end
            S_SQRT:     o_cmd.sqrt_step = 1'b1;
            S_DEV_DONE: o_cmd.dev_store = 1'b1;
            S_PCT_CHECK: begin
                o_cmd.div_start = i_status.need_pct;
                o_cmd.div_sel   = DIV_PCT;
            end
            S_PCT_DIV: begin
                o_cmd.div_sel   = DIV_PCT;
                o_cmd.pct_store = !i_status.div_busy;
            end
            S_MEAN_GO:  o_cmd.div_start = 1'b1;
            S_MEAN_DIV: o_cmd.mean_store = !i_status.div_busy;
            S_DONE:     o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/running_statistics_accumulator_core.sv */
// A clear beat, or a sample on a full counter, goes straight to the result
// register; any other sample passes the mean division, and with variance,
// deviation and percentage also the shift-add multiplier (64 steps) and the
// serial divider (one quotient bit per cycle, up to 88 bits).
// One beat at a time: the next beat is taken the cycle after the result loads.
// Reset (synchronous, active low) zeroes configuration and all statistics.
// ----------------------------------------------------------------------------
// running_statistics_accumulator_core
// Running mean, sample variance, deviation, min/max and match count over a
// stream of signed samples.
// ----------------------------------------------------------------------------
module running_statistics_accumulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rsa_in_if.sink                        i_item,
    rsa_out_if.source                     o_result,
    input  logic                          i_cfg_we,
    input  logic [rsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rsa_pkg::CFG_W-1:0]     i_cfg_data
);
    import rsa_pkg::*;

    t_cmd    cmd;
    t_status status;

    rsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rsa_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_in_op           (i_item.op),
        .i_in_sample       (i_item.sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_res_valid       (o_result.valid),
        .i_res_ready       (o_result.ready),
        .o_min_value       (o_result.min_value),
        .o_max_value       (o_result.max_value),
        .o_mean_value      (o_result.mean_value),
        .o_variance_value  (o_result.variance_value),
        .o_deviation_value (o_result.deviation_value),
        .o_match_count     (o_result.match_count),
        .o_match_percent   (o_result.match_percent),
        .o_samples_seen    (o_result.samples_seen),
        .o_saturated       (o_result.saturated)
    );

endmodule

/* hdl/rsa_checker.sv */
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks on the result channel of the accumulator.
// ----------------------------------------------------------------------------
module rsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [rsa_pkg::COUNT_W-1:0]   i_samples_seen,
    input logic [rsa_pkg::COUNT_W-1:0]   i_match_count,
    input logic [rsa_pkg::PCT_W-1:0]     i_match_percent,
    input logic                          i_saturated
);
    import rsa_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_samples_seen))
        else $error("stalled result changed");

    // matches never outnumber samples
    a_match_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_match_count <= i_samples_seen)
        else $error("match count above sample count");

    // saturation only with a full counter
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_saturated |-> &i_samples_seen)
        else $error("saturated without full count");

    // percentage bounded by 100
    a_pct_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_match_percent <= PCT_W'(PCT_SCALE << FRAC_W))
        else $error("percentage above 100");

endmodule

bind running_statistics_accumulator_core rsa_checker u_rsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_result.valid),
    .i_ready         (o_result.ready),
    .i_samples_seen  (o_result.samples_seen),
    .i_match_count   (o_result.match_count),
    .i_match_percent (o_result.match_percent),
    .i_saturated     (o_result.saturated)
);

/* bench/tb_running_statistics_accumulator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_statistics_accumulator_core
// Feeds sample and clear beats into the statistics core under random source
// gaps and sink stalls, and keeps its own running statistics to predict every
// result beat. Feature masks, match enable and match value are swept across
// phases, and the core is drained idle before each register write.
// ----------------------------------------------------------------------------
module tb_running_statistics_accumulator_core;
    import rsa_pkg::*;

    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE_CYC  = 320;
    localparam logic [39:0] VAR_SAT     = 40'hFF_FFFF_FFFF;
    localparam logic [23:0] DEV_SAT     = 24'hFF_FFFF;

    typedef struct {
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic signed [23:0] mean_value;
        logic [39:0]        variance_value;
        logic [23:0]        deviation_value;
        logic [23:0]        match_count;
        logic [14:0]        match_percent;
        logic [23:0]        samples_seen;
        logic               saturated;
    } stats_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    rsa_in_if  item_ch ();
    rsa_out_if result_ch ();

    running_statistics_accumulator_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch.sink),
        .o_result   (result_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted statistics and configuration
    logic [FEAT_W-1:0]   feat_mask;
    logic                match_on;
    logic signed [15:0]  match_target;
    logic [23:0]         n_samples;
    longint              sum_acc;
    logic [55:0]         sq_acc;
    logic signed [15:0]  min_acc;
    logic signed [15:0]  max_acc;
    logic [23:0]         hits_acc;
    logic [39:0]         var_acc;
    logic [23:0]         dev_acc;
    logic [14:0]         pct_acc;
    logic                full_acc;

    stats_result_t pending_stats[$];
    int            mismatch_count;
    int            burst_left;
    int            cycle_count;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run-away guard
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // floor((n*sumsq - sum^2) << F / (n(n-1))), clamped
    function automatic logic [39:0] sample_variance(logic [23:0] n);
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] mag_sum;
        logic [127:0] quo;
        mag_sum = (sum_acc < 0) ? -sum_acc : sum_acc;
        lhs     = 128'(n) * 128'(sq_acc);
        rhs     = mag_sum * mag_sum;
        if (rhs > lhs) return '0;
        quo = ((lhs - rhs) << FRAC_W) / (128'(n) * 128'(n - 1));
        return (quo > VAR_SAT) ? VAR_SAT : quo[39:0];
    endfunction

    // rounded mean, ties away from zero
    function automatic logic [23:0] running_mean();
        longint mag_sum;
        longint q;
        if (n_samples == 0) return '0;
        mag_sum = (sum_acc < 0) ? -sum_acc : sum_acc;
        q = ((mag_sum << FRAC_W) + n_samples / 2) / n_samples;
        if (sum_acc < 0) q = -q;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[23:0];
    endfunction

    task automatic clear_stats();
        n_samples = 0; sum_acc = 0; sq_acc = 0; min_acc = 0; max_acc = 0;
        hits_acc = 0; var_acc = 0; dev_acc = 0; pct_acc = 0; full_acc = 0;
    endtask

    // update the running statistics for one beat and queue the result
    task automatic predict_stats(logic op, logic signed [15:0] x);
        stats_result_t r;
        logic [39:0]   v;
        logic [63:0]   root;
        longint        mag_x;
        if (op == OP_CLEAR) begin
            clear_stats();
        end else if (n_samples == DEV_SAT) begin
            full_acc = 1'b1;
        end else begin
            n_samples++;
            sum_acc += x;
            mag_x = (x < 0) ? -longint'(x) : longint'(x);
            sq_acc += 56'(mag_x * mag_x);
            if (match_on && x == match_target) hits_acc++;
            if (feat_mask[FE_MIN]) min_acc = (n_samples > 1 && min_acc < x) ? min_acc : x;
            if (feat_mask[FE_MAX]) max_acc = (n_samples > 1 && max_acc > x) ? max_acc : x;
            if (n_samples > 1 && (feat_mask[FE_VAR] || feat_mask[FE_DEV])) begin
                v = sample_variance(n_samples);
                if (feat_mask[FE_VAR]) var_acc = v;
                if (feat_mask[FE_DEV]) begin
                    root    = isqrt(64'(v) << FRAC_W);
                    dev_acc = (root > DEV_SAT) ? DEV_SAT : root[23:0];
                end
            end
            if (feat_mask[FE_PCT] && match_on)
                pct_acc = 15'(((64'(hits_acc) * PCT_SCALE) << FRAC_W) / n_samples);
        end
        r.min_value       = feat_mask[FE_MIN] ? min_acc : '0;
        r.max_value       = feat_mask[FE_MAX] ? max_acc : '0;
        r.mean_value      = running_mean();
        r.variance_value  = feat_mask[FE_VAR] ? var_acc : '0;
        r.deviation_value = feat_mask[FE_DEV] ? dev_acc : '0;
        r.match_count     = hits_acc;
        r.match_percent   = feat_mask[FE_PCT] ? pct_acc : '0;
        r.samples_seen    = n_samples;
        r.saturated       = full_acc;
        pending_stats.insert(pending_stats.size(), r);
    endtask

    function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // result sink: stall pattern plus checking of each accepted beat
    initial begin
        stats_result_t e;
        int            stall_mode;
        int            mode_left;
        result_ch.ready <= 1'b0;
        stall_mode = 0;
        mode_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                if (pending_stats.size() == 0) begin
                    $error("result beat with no prediction pending");
                    mismatch_count++;
                end else begin
                    e = pending_stats.pop_front();
                    compare_field("min_value", 64'(e.min_value), 64'(result_ch.min_value));
                    compare_field("max_value", 64'(e.max_value), 64'(result_ch.max_value));
                    compare_field("mean_value", 64'(e.mean_value), 64'(result_ch.mean_value));
                    compare_field("variance_value", 64'(e.variance_value),
                                  64'(result_ch.variance_value));
                    compare_field("deviation_value", 64'(e.deviation_value),
                                  64'(result_ch.deviation_value));
                    compare_field("match_count", 64'(e.match_count),
                                  64'(result_ch.match_count));
                    compare_field("match_percent", 64'(e.match_percent),
                                  64'(result_ch.match_percent));
                    compare_field("samples_seen", 64'(e.samples_seen),
                                  64'(result_ch.samples_seen));
                    compare_field("saturated", 64'(e.saturated), 64'(result_ch.saturated));
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 1) == 1);
                default: result_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // one beat, with bursts and random gaps on the source side
    task automatic send_beat(logic op, logic signed [15:0] x);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        item_ch.valid  <= 1'b1;
        item_ch.op     <= op;
        item_ch.sample <= x;
        do @(posedge i_clk); while (!item_ch.ready);
        predict_stats(op, x);
    endtask

    // stop sending and let every pending result drain
    task automatic drain_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FEATURE:  feat_mask    = data[FEAT_W-1:0];
            REG_MATCH_EN: match_on     = data[0];
            default:      match_target = data;
        endcase
    endtask

    task automatic apply_config(logic [4:0] fe, logic men, logic signed [15:0] mval);
        drain_idle();
        write_reg(REG_FEATURE, 16'(fe));
        write_reg(REG_MATCH_EN, 16'(men));
        write_reg(REG_MATCH_VAL, mval);
    endtask

    // extremes of the sample range with every feature on
    task automatic test_extremes();
        apply_config(5'h1F, 1'b1, -16'sd32768);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_ADD, -16'sd32768);
        send_beat(OP_ADD, -16'sd32768);
        send_beat(OP_ADD, 16'sd0);
        send_beat(OP_ADD, -16'sd1);
        send_beat(OP_ADD, 16'sd1);
        send_beat(OP_CLEAR, 16'sd1234);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_ADD, -16'sd32768);
    endtask

    // features off over two samples, then constant samples with variance and deviation on (zero variance)
    task automatic test_features_off();
        apply_config(5'h00, 1'b0, 16'sd32767);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_ADD, 16'sd100);
        send_beat(OP_CLEAR, 16'sd0);
        apply_config(5'h0C, 1'b1, 16'sd32767);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_ADD, 16'sd32767);
        send_beat(OP_CLEAR, -16'sd1);
        send_beat(OP_CLEAR, 16'sd0);
    endtask

    // random samples under one configuration, clears now and then
    task automatic test_random_phase(logic [4:0] fe, logic men, logic signed [15:0] mval,
                                     int count);
        logic signed [15:0] x;
        apply_config(fe, men, mval);
        send_beat(OP_CLEAR, 16'($urandom()));
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1:    x = mval;
                2:       x = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                3:       x = 16'($urandom_range(0, 15)) - 16'sd8;
                default: x = 16'($urandom());
            endcase
            if ($urandom_range(0, 39) == 0) send_beat(OP_CLEAR, x);
            else send_beat(OP_ADD, x);
        end
    endtask

    initial begin
        mismatch_count = 0;
        burst_left     = 0;
        feat_mask      = '0;
        match_on       = 1'b0;
        match_target   = '0;
        clear_stats();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= REG_FEATURE;
        i_cfg_data     <= '0;
        item_ch.valid  <= 1'b0;
        item_ch.op     <= OP_ADD;
        item_ch.sample <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_features_off();
        test_random_phase(5'h1F, 1'b1, 16'($urandom()), 120);
        test_random_phase(5'h00, 1'b1, 16'sd0, 80);
        test_random_phase(5'($urandom()), 1'b1, 16'($urandom_range(0, 15)) - 16'sd8, 120);
        test_random_phase(5'h13, 1'b0, -16'sd1, 80);
        test_random_phase(5'h1F, 1'b1, 16'sd32767, 100);
        test_random_phase(5'($urandom()), $urandom_range(0, 1), 16'($urandom()), 100);

        drain_idle();
        if (mismatch_count == 0 && pending_stats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
